### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the epoch-to-calendar converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/e2c_pkg.sv
// Package with constants, types and calendar functions for the epoch-to-calendar converter.
`default_nettype none

package e2c_pkg;

   localparam int SECONDS_BITS_DEF = 34;

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int YLEN_W  = 9;

   localparam logic [YEAR_W-1:0]  FIRST_YEAR    = 12'd1970;
   localparam logic [6:0]         FIRST_MOD100  = 7'd70;
   localparam logic [8:0]         FIRST_MOD400  = 9'd370;
   localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;

   // Control from the sequencer to the year tracker.
   typedef struct packed {
      logic init;
      logic advance;
   } e2c_year_ctl_type;

   function automatic logic [YLEN_W-1:0] year_length(input logic leap);
      return leap ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] mon,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (mon)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/epoch_seconds_to_calendar.sv
// Top level: converts seconds since 1970-01-01 into Gregorian date and time of day.
//
//   channel   direction  handshake          ports
//   request   in         start & !busy      req_epoch_seconds
//   response  out        rsp_valid strobe   rsp_year rsp_month rsp_day rsp_hour
//                                           rsp_minute rsp_second
//
// A transaction runs the restoring division by 86400 over QW = SECONDS_BITS - 16 quotient
// bits, then the divisions into hours and minutes, then year steps that count the whole
// years past 1970 and month steps that count the whole months past January, and then the
// response strobe; the sequencer returns to idle before it accepts the next request.
// All steps go through one shared compare-and-subtract unit under the sequencer.
// busy is high from the accepting edge until the response strobe; reset returns to idle.
// The response is presented for one cycle only and cannot be stalled.
`default_nettype none
`include "assert_macros.svh"

module epoch_seconds_to_calendar #(
   parameter int SECONDS_BITS = e2c_pkg::SECONDS_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [SECONDS_BITS-1:0]       req_epoch_seconds,
   output logic                               rsp_valid,
   output logic [e2c_pkg::YEAR_W-1:0]         rsp_year,
   output logic [e2c_pkg::MONTH_W-1:0]        rsp_month,
   output logic [e2c_pkg::DAY_W-1:0]          rsp_day,
   output logic [e2c_pkg::HOUR_W-1:0]         rsp_hour,
   output logic [e2c_pkg::MIN_W-1:0]          rsp_minute,
   output logic [e2c_pkg::SEC_W-1:0]          rsp_second
);
   import e2c_pkg::*;

   localparam int SB     = SECONDS_BITS;
   localparam int QW     = SB - 16;
   localparam int STEP_W = $clog2(QW);

   localparam logic [SB-1:0] DAY_DIV_INIT  = SB'(SECS_PER_DAY) << (QW - 1);
   localparam logic [SB-1:0] HOUR_DIV_INIT = SB'(SECS_PER_HOUR) << (HOUR_W - 1);
   localparam logic [SB-1:0] MIN_DIV_INIT  = SB'(SECS_PER_MIN) << (MIN_W - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DDAY  = 3'd1;
   localparam logic [2:0] ST_DHOUR = 3'd2;
   localparam logic [2:0] ST_DMIN  = 3'd3;
   localparam logic [2:0] ST_YEAR  = 3'd4;
   localparam logic [2:0] ST_MONTH = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [SB-1:0]       rem_ff, rem_in;
   logic [SB-1:0]       div_ff, div_in;
   logic [QW-1:0]       days_ff, days_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MIN_W-1:0]    minute_ff, minute_in;
   logic [MONTH_W-1:0]  month_ff, month_in;

   logic [SB-1:0]       op_a;
   logic [SB-1:0]       op_b;
   logic [SB-1:0]       diff;
   logic                ge;

   e2c_year_ctl_type    year_ctl;
   logic [YEAR_W-1:0]   year;
   logic                leap;

   e2c_year_tracker u_year (
      .clock (clock),
      .ctl   (year_ctl),
      .year  (year),
      .leap  (leap)
   );

   // Shared compare-and-subtract unit.
   always_comb begin
      case (state_ff)
         ST_YEAR: begin
            op_a = SB'(days_ff);
            op_b = SB'(year_length(leap));
         end
         ST_MONTH: begin
            op_a = SB'(days_ff);
            op_b = SB'(month_length(month_ff, leap));
         end
         default: begin
            op_a = rem_ff;
            op_b = div_ff;
         end
      endcase
   end

   assign diff = op_a - op_b;
   assign ge   = (op_a >= op_b);

   always_comb begin
      state_in         = state_ff;
      rem_in           = rem_ff;
      div_in           = div_ff;
      days_in          = days_ff;
      step_in          = step_ff;
      hour_in          = hour_ff;
      minute_in        = minute_ff;
      month_in         = month_ff;
      year_ctl.init    = 1'b0;
      year_ctl.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rem_in   = req_epoch_seconds;
               div_in   = DAY_DIV_INIT;
               step_in  = STEP_W'(QW - 1);
               days_in  = '0;
               state_in = ST_DDAY;
            end
         end
         // Restoring division, one quotient bit per cycle, high bit first.
         ST_DDAY: begin
            if (ge) begin
               rem_in = diff;
            end
            days_in = {days_ff[QW-2:0], ge};
            div_in  = div_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               div_in   = HOUR_DIV_INIT;
               step_in  = STEP_W'(HOUR_W - 1);
               state_in = ST_DHOUR;
            end
         end
         ST_DHOUR: begin
            if (ge) begin
               rem_in = diff;
            end
            hour_in = {hour_ff[HOUR_W-2:0], ge};
            div_in  = div_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               div_in   = MIN_DIV_INIT;
               step_in  = STEP_W'(MIN_W - 1);
               state_in = ST_DMIN;
            end
         end
         ST_DMIN: begin
            if (ge) begin
               rem_in = diff;
            end
            minute_in = {minute_ff[MIN_W-2:0], ge};
            div_in    = div_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (step_ff == '0) begin
               year_ctl.init = 1'b1;
               state_in      = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (ge) begin
               days_in          = diff[QW-1:0];
               year_ctl.advance = 1'b1;
            end else begin
               month_in = MONTH_JAN;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            // The remainder is always shorter than the year, so December never overflows.
            if (ge && (month_ff != MONTH_DEC)) begin
               days_in  = diff[QW-1:0];
               month_in = month_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      days_ff   <= days_in;
      step_ff   <= step_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      month_ff  <= month_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_DONE);
   assign rsp_year   = year;
   assign rsp_month  = month_ff;
   assign rsp_day    = days_ff[DAY_W-1:0] + 1'b1;
   assign rsp_hour   = hour_ff;
   assign rsp_minute = minute_ff;
   assign rsp_second = rem_ff[SEC_W-1:0];

   `ASSERT_CLK(a_accept_goes_busy, clock, reset, (start && !busy) |=> busy, "accepted transaction did not raise busy")
   `ASSERT_CLK(a_strobe_then_idle, clock, reset, rsp_valid |=> (!busy && !rsp_valid), "response strobe lasted more than one cycle")
   `ASSERT_CLK(a_month_range, clock, reset, rsp_valid |-> ((rsp_month >= MONTH_JAN) && (rsp_month <= MONTH_DEC)), "month out of range")
   `ASSERT_CLK(a_time_range, clock, reset, rsp_valid |-> ((rsp_hour < 5'd24) && (rsp_minute < 6'd60) && (rsp_second < 6'd60)), "time of day out of range")
   `ASSERT_CLK(a_day_range, clock, reset, rsp_valid |-> ((rsp_day != 5'd0) && (days_ff < QW'(31))), "day of month out of range")
   `ASSERT_CLK_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy, "not idle after reset")

endmodule

`default_nettype wire

### hw/rtl/e2c_year_tracker.sv
// Year counter with running mod-100 and mod-400 residues for the Gregorian leap rule.
`default_nettype none

module e2c_year_tracker (
   input  wire logic                       clock,
   input  wire e2c_pkg::e2c_year_ctl_type  ctl,
   output logic [e2c_pkg::YEAR_W-1:0]      year,
   output logic                            leap
);
   import e2c_pkg::*;

   logic [YEAR_W-1:0] year_ff, year_in;
   logic [6:0]        mod100_ff, mod100_in;
   logic [8:0]        mod400_ff, mod400_in;

   // The residues track the true year, so the leap rule stays right even after
   // the twelve-bit year wraps; 4096 is a multiple of four.
   always_comb begin
      year_in   = year_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      if (ctl.init) begin
         year_in   = FIRST_YEAR;
         mod100_in = FIRST_MOD100;
         mod400_in = FIRST_MOD400;
      end else if (ctl.advance) begin
         year_in   = year_ff + 1'b1;
         mod100_in = (mod100_ff == 7'd99)  ? 7'd0 : mod100_ff + 1'b1;
         mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
   end

   assign year = year_ff;
   assign leap = (year_ff[1:0] == 2'b00) && ((mod100_ff != 7'd0) || (mod400_ff == 9'd0));

endmodule

`default_nettype wire
